### hdl/ebp_pkg.sv
// shared types and constants for the eased cubic bezier point unit
package ebp_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int T_BITS         = 17;
  localparam int FRAC_BITS      = 16;
  localparam int DIV_BITS       = 8;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [T_BITS-1:0]   T_ONE       = T_BITS'(65536);
  localparam logic [DIV_BITS-1:0] TWEEN_RESET = DIV_BITS'(16);
  localparam logic                ANIM_RESET  = 1'b1;

  // configuration register indexes
  localparam logic CFG_TWEEN = 1'b0;
  localparam logic CFG_ANIM  = 1'b1;

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_PLOT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STEP_B  = 2'd0,
    STEP_C  = 2'd1,
    STEP_P0 = 2'd2
  } step_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COEF1,
    ST_COEF2,
    ST_MUL,
    ST_ADD,
    ST_DLOAD,
    ST_DIV,
    ST_DSTORE,
    ST_OUT
  } state_e;

endpackage

### hdl/eased_cubic_bezier_point.sv
// eased cubic bezier point unit: point store, tick easing divider, plot sequencer
//
// Keeps four current and four target control points in signed fixed point with
// 8 fraction bits. A plot beat evaluates the curve in Horner form on one shared
// multiplier, x axis then y axis, and holds the input until its result enters
// the output register, which waits while the output is stalled. A tick beat
// with animation on runs the eight coordinates one after another through a
// restoring divider that retires one quotient bit a cycle; with animation off a
// tick leaves the points unchanged. in_stall_o is high for the whole time a beat
// is being worked on. Only plot beats give a result.
module eased_cubic_bezier_point
  import ebp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [1:0]                   point_index_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic [T_BITS-1:0]            param_t_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] curve_x_o,
  output logic signed [COORD_BITS-1:0] curve_y_o
);

  localparam int CB    = COORD_BITS;
  localparam int W     = CB + 5;             // horner accumulator width
  localparam int PW    = W + T_BITS + 1;     // product width
  localparam int MW    = CB + 1;             // divider magnitude width
  localparam int CNT_W = $clog2(CB + 1);
  localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(CB);
  localparam int RndHalf = 1 << (FRAC_BITS - 1);

  state_e state_q, state_d;

  logic [DIV_BITS-1:0] tween_q, tween_d;
  logic                anim_q, anim_d;

  logic signed [CB-1:0] cur_x_q [4];
  logic signed [CB-1:0] cur_y_q [4];
  logic signed [CB-1:0] tgt_x_q [4];
  logic signed [CB-1:0] tgt_y_q [4];
  logic signed [CB-1:0] cur_x_d [4];
  logic signed [CB-1:0] cur_y_d [4];
  logic signed [CB-1:0] tgt_x_d [4];
  logic signed [CB-1:0] tgt_y_d [4];

  logic             axis_q, axis_d;
  logic [1:0]       pt_q, pt_d;
  step_e            step_q, step_d;
  logic [CNT_W-1:0] bit_q, bit_d;

  logic [T_BITS-1:0]   t_q, t_d;
  logic signed [W-1:0] c_q, c_d;
  logic signed [W-1:0] b_q, b_d;
  logic signed [W-1:0] d21_q, d21_d;
  logic signed [W-1:0] d30_q, d30_d;
  logic signed [W-1:0] acc_q, acc_d;
  logic signed [PW-1:0] prod_q, prod_d;

  logic [DIV_BITS-1:0] dvsr_q, dvsr_d;
  logic [DIV_BITS-1:0] rem_q, rem_d;
  logic [MW-1:0]       dvd_q, dvd_d;
  logic                neg_q, neg_d;

  logic signed [CB-1:0] res_x_q, res_x_d;
  logic signed [CB-1:0] res_y_q, res_y_d;
  logic signed [CB-1:0] out_x_q, out_x_d;
  logic signed [CB-1:0] out_y_q, out_y_d;
  logic                 out_valid_q, out_valid_d;

  logic in_acc;
  logic out_free;

  // datapath helpers
  logic signed [W-1:0]  pw [4];
  logic signed [W-1:0]  diff10, diff21, diff30;
  logic signed [PW-1:0] rsum;
  logic signed [W-1:0]  rnd;
  logic signed [W-1:0]  addend;
  logic signed [W-1:0]  horner;
  logic signed [CB-1:0] horner_sat;
  logic signed [CB-1:0] cur_sel, tgt_sel;
  logic signed [CB:0]   ediff;
  logic [DIV_BITS:0]    rem_sh;
  logic                 quo_bit;
  logic signed [CB+1:0] eased;

  function automatic logic signed [CB-1:0] sat_coord(input logic signed [W-1:0] v);
    logic ovf;
    ovf = (v[W-1:CB-1] != {(W-CB+1){v[W-1]}});
    if (!ovf) begin
      return v[CB-1:0];
    end else if (v[W-1]) begin
      return {1'b1, {(CB-1){1'b0}}};
    end else begin
      return {1'b0, {(CB-1){1'b1}}};
    end
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign curve_x_o   = out_x_q;
  assign curve_y_o   = out_y_q;

  // arithmetic shared by the sequencer steps
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pw[i] = axis_q ? W'(cur_y_q[i]) : W'(cur_x_q[i]);
    end
    diff10 = pw[1] - pw[0];
    diff21 = pw[2] - pw[1];
    diff30 = pw[3] - pw[0];

    // round half up, then drop the 16 fraction bits of t
    rsum = prod_q + PW'(RndHalf);
    rnd  = rsum[W+FRAC_BITS-1:FRAC_BITS];
    case (step_q)
      STEP_B:  addend = b_q;
      STEP_C:  addend = c_q;
      STEP_P0: addend = pw[0];
      default: addend = pw[0];
    endcase
    horner     = rnd + addend;
    horner_sat = sat_coord(horner);

    cur_sel = axis_q ? cur_y_q[pt_q] : cur_x_q[pt_q];
    tgt_sel = axis_q ? tgt_y_q[pt_q] : tgt_x_q[pt_q];
    ediff   = (CB+1)'(tgt_sel) - (CB+1)'(cur_sel);

    rem_sh  = {rem_q, dvd_q[MW-1]};
    quo_bit = (rem_sh >= {1'b0, dvsr_q});

    // quotient truncated toward zero, sign put back
    if (neg_q) begin
      eased = (CB+2)'(cur_sel) - $signed({1'b0, dvd_q});
    end else begin
      eased = (CB+2)'(cur_sel) + $signed({1'b0, dvd_q});
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind_e'(kind_i))
            KIND_TICK: state_d = anim_q ? ST_DLOAD : ST_IDLE;
            KIND_PLOT: state_d = ST_COEF1;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_COEF1:  state_d = ST_COEF2;
      ST_COEF2:  state_d = ST_MUL;
      ST_MUL:    state_d = ST_ADD;
      ST_ADD: begin
        if (step_q == STEP_P0) begin
          state_d = axis_q ? ST_OUT : ST_COEF1;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_DLOAD:  state_d = ST_DIV;
      ST_DIV:    state_d = (bit_q == BIT_LAST) ? ST_DSTORE : ST_DIV;
      ST_DSTORE: state_d = (axis_q && pt_q == 2'd3) ? ST_IDLE : ST_DLOAD;
      ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and register updates
  always_comb begin
    tween_d     = tween_q;
    anim_d      = anim_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    axis_d      = axis_q;
    pt_d        = pt_q;
    step_d      = step_q;
    bit_d       = bit_q;
    t_d         = t_q;
    c_d         = c_q;
    b_d         = b_q;
    d21_d       = d21_q;
    d30_d       = d30_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    dvsr_d      = dvsr_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    neg_d       = neg_q;
    res_x_d     = res_x_q;
    res_y_d     = res_y_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TWEEN: tween_d = cfg_data_i[DIV_BITS-1:0];
        CFG_ANIM:  anim_d  = cfg_data_i[0];
        default:   tween_d = tween_q;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        axis_d = 1'b0;
        pt_d   = 2'd0;
        step_d = STEP_B;
        if (in_acc) begin
          case (kind_e'(kind_i))
            KIND_SET: begin
              tgt_x_d[point_index_i] = point_x_i;
              tgt_y_d[point_index_i] = point_y_i;
              if (!anim_q) begin
                cur_x_d[point_index_i] = point_x_i;
                cur_y_d[point_index_i] = point_y_i;
              end
            end
            KIND_TICK: begin
              dvsr_d = (tween_q == '0) ? DIV_BITS'(1) : tween_q;
            end
            KIND_PLOT: begin
              t_d = (param_t_i > T_ONE) ? T_ONE : param_t_i;
            end
            default: t_d = t_q;
          endcase
        end
      end
      ST_COEF1: begin
        c_d   = (diff10 <<< 1) + diff10;
        d21_d = (diff21 <<< 1) + diff21;
        d30_d = diff30;
      end
      ST_COEF2: begin
        // a = (p3 - p0) - c - b collapses to (p3 - p0) - 3(p2 - p1)
        b_d    = d21_q - c_q;
        acc_d  = d30_q - d21_q;
        step_d = STEP_B;
      end
      ST_MUL: begin
        prod_d = acc_q * $signed({1'b0, t_q});
      end
      ST_ADD: begin
        acc_d = horner;
        case (step_q)
          STEP_B:  step_d = STEP_C;
          STEP_C:  step_d = STEP_P0;
          STEP_P0: begin
            step_d = STEP_B;
            if (axis_q) begin
              res_y_d = horner_sat;
            end else begin
              res_x_d = horner_sat;
              axis_d  = 1'b1;
            end
          end
          default: step_d = STEP_B;
        endcase
      end
      ST_DLOAD: begin
        neg_d = ediff[CB];
        dvd_d = ediff[CB] ? MW'(-ediff) : MW'(ediff);
        rem_d = '0;
        bit_d = '0;
      end
      ST_DIV: begin
        rem_d = quo_bit ? DIV_BITS'(rem_sh - {1'b0, dvsr_q}) : rem_sh[DIV_BITS-1:0];
        dvd_d = {dvd_q[MW-2:0], quo_bit};
        bit_d = bit_q + CNT_W'(1);
      end
      ST_DSTORE: begin
        if (axis_q) begin
          cur_y_d[pt_q] = eased[CB-1:0];
        end else begin
          cur_x_d[pt_q] = eased[CB-1:0];
        end
        // x axis points first, then y axis
        if (pt_q == 2'd3) begin
          pt_d   = 2'd0;
          axis_d = 1'b1;
        end else begin
          pt_d = pt_q + 2'd1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_x_d     = res_x_q;
          out_y_d     = res_y_q;
          out_valid_d = 1'b1;
        end
      end
      default: acc_d = acc_q;
    endcase
  end

  // control state and point store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tween_q     <= TWEEN_RESET;
      anim_q      <= ANIM_RESET;
      axis_q      <= 1'b0;
      pt_q        <= 2'd0;
      step_q      <= STEP_B;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cur_x_q[i] <= '0;
        cur_y_q[i] <= '0;
        tgt_x_q[i] <= '0;
        tgt_y_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      tween_q     <= tween_d;
      anim_q      <= anim_d;
      axis_q      <= axis_d;
      pt_q        <= pt_d;
      step_q      <= step_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    c_q     <= c_d;
    b_q     <= b_d;
    d21_q   <= d21_d;
    d30_q   <= d30_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    dvsr_q  <= dvsr_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    neg_q   <= neg_d;
    res_x_q <= res_x_d;
    res_y_q <= res_y_d;
    out_x_q <= out_x_d;
    out_y_q <= out_y_d;
  end

endmodule

### test/tb_eased_cubic_bezier_point.sv
// testbench for the eased cubic bezier point unit: random beats against a predictor
`timescale 1ns / 1ps

module tb_eased_cubic_bezier_point
  import ebp_pkg::*;
;

  localparam int          CB           = COORD_BITS_DEF;
  localparam longint      CMAX         = (longint'(1) <<< (CB - 1)) - 1;
  localparam longint      CMIN         = -(longint'(1) <<< (CB - 1));
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int          DRAIN_CYCLES = 260;
  localparam int          HOLD_CYCLES  = 400;
  localparam longint      CYCLE_LIMIT  = 3000000;

  typedef struct {
    logic [1:0]          kind;
    logic [1:0]          idx;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic [T_BITS-1:0]   t;
  } beat_t;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
  } point_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic                     cfg_idx_i     = CFG_TWEEN;
  logic [CFG_DATA_BITS-1:0] cfg_data_i    = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               kind_i        = KIND_SET;
  logic [1:0]               point_index_i = '0;
  logic signed [CB-1:0]     point_x_i     = '0;
  logic signed [CB-1:0]     point_y_i     = '0;
  logic [T_BITS-1:0]        param_t_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic signed [CB-1:0]     curve_x_o;
  logic signed [CB-1:0]     curve_y_o;

  // predictor state and configuration copy
  logic signed [CB-1:0] cur_x [4];
  logic signed [CB-1:0] cur_y [4];
  logic signed [CB-1:0] tgt_x [4];
  logic signed [CB-1:0] tgt_y [4];
  logic [DIV_BITS-1:0]  tween_div_q = TWEEN_RESET;
  logic                 anim_en_q   = ANIM_RESET;

  beat_t  beats_to_send [$];
  point_t plot_expect_q [$];
  beat_t  offered;

  int     tx_idle_pct  = 0;
  int     rx_stall_pct = 0;
  bit     hold_arm     = 1'b0;
  bit     hold_done    = 1'b0;
  int     hold_left    = 0;
  int     err_cnt      = 0;
  longint cycle_cnt    = 0;

  eased_cubic_bezier_point #(
    .COORD_BITS(CB)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .param_t_i     (param_t_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .curve_x_o     (curve_x_o),
    .curve_y_o     (curve_y_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < 4; i++) begin
      cur_x[i] = '0;
      cur_y[i] = '0;
      tgt_x[i] = '0;
      tgt_y[i] = '0;
    end
  end

  // horner evaluation, every step rounded half up
  function automatic logic signed [CB-1:0] bezier_axis(input longint p0, input longint p1,
                                                       input longint p2, input longint p3,
                                                       input longint t);
    longint c;
    longint b;
    longint a;
    longint r;
    c = 3 * (p1 - p0);
    b = 3 * (p2 - p1) - c;
    a = p3 - p0 - c - b;
    r = ((a * t + 32768) >>> 16) + b;
    r = ((r * t + 32768) >>> 16) + c;
    r = ((r * t + 32768) >>> 16) + p0;
    if (r > CMAX) r = CMAX;
    else if (r < CMIN) r = CMIN;
    return r[CB-1:0];
  endfunction

  task automatic apply_beat(input beat_t bt);
    longint div;
    longint t;
    longint nv;
    point_t pt;
    case (bt.kind)
      KIND_SET: begin
        tgt_x[bt.idx] = bt.x;
        tgt_y[bt.idx] = bt.y;
        if (!anim_en_q) begin
          cur_x[bt.idx] = bt.x;
          cur_y[bt.idx] = bt.y;
        end
      end
      KIND_TICK: begin
        div = (tween_div_q == 0) ? 1 : longint'(tween_div_q);
        if (anim_en_q) begin
          for (int i = 0; i < 4; i++) begin
            // signed division truncates toward zero
            nv = longint'(cur_x[i]) + (longint'(tgt_x[i]) - longint'(cur_x[i])) / div;
            cur_x[i] = nv[CB-1:0];
            nv = longint'(cur_y[i]) + (longint'(tgt_y[i]) - longint'(cur_y[i])) / div;
            cur_y[i] = nv[CB-1:0];
          end
        end
      end
      KIND_PLOT: begin
        t = (bt.t > T_ONE) ? longint'(T_ONE) : longint'(bt.t);
        pt.x = bezier_axis(cur_x[0], cur_x[1], cur_x[2], cur_x[3], t);
        pt.y = bezier_axis(cur_y[0], cur_y[1], cur_y[2], cur_y[3], t);
        plot_expect_q.push_back(pt);
      end
      default: ;
    endcase
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) apply_beat(offered);
      if (!in_valid_i || !in_stall_o) begin
        if (beats_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered = beats_to_send.pop_front();
          kind_i        <= offered.kind;
          point_index_i <= offered.idx;
          point_x_i     <= offered.x;
          point_y_i     <= offered.y;
          param_t_i     <= offered.t;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output stall, with one long hold-off when armed
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    point_t exp_pt;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (plot_expect_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, curve_x_o, curve_y_o);
        err_cnt <= err_cnt + 1;
      end else begin
        exp_pt = plot_expect_q.pop_front();
        if (curve_x_o !== exp_pt.x || curve_y_o !== exp_pt.y) begin
          if (curve_x_o !== exp_pt.x)
            $display("%0t: curve_x expected %0d actual %0d", $time, exp_pt.x, curve_x_o);
          if (curve_y_o !== exp_pt.y)
            $display("%0t: curve_y expected %0d actual %0d", $time, exp_pt.y, curve_y_o);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_beat(input logic [1:0] kind, input logic [1:0] idx,
                           input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                           input logic [T_BITS-1:0] t);
    beat_t bt;
    bt.kind = kind;
    bt.idx  = idx;
    bt.x    = x;
    bt.y    = y;
    bt.t    = t;
    beats_to_send.push_back(bt);
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    logic signed [CB-1:0] v;
    case ($urandom_range(9))
      0: v = CMAX[CB-1:0];
      1: v = CMIN[CB-1:0];
      2, 3, 4: v = CB'($signed($urandom_range(8192)) - 4096);
      default: v = CB'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [T_BITS-1:0] rand_t();
    logic [T_BITS-1:0] v;
    case ($urandom_range(7))
      0: v = T_ONE;
      1: v = '0;
      2: v = T_BITS'($urandom);
      default: v = T_BITS'($urandom_range(65536));
    endcase
    return v;
  endfunction

  task automatic push_random(input int plot_pct);
    int r;
    logic [1:0] kind;
    r = $urandom_range(99);
    if (r < 2) kind = KIND_UNUSED;
    else if (r < 2 + plot_pct) kind = KIND_PLOT;
    else if (r < 22 + plot_pct) kind = KIND_TICK;
    else kind = KIND_SET;
    push_beat(kind, 2'($urandom_range(3)), rand_coord(), rand_coord(), rand_t());
  endtask

  task automatic write_cfg(input logic idx, input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TWEEN) tween_div_q = data;
    else anim_en_q = data[0];
  endtask

  // ticks give no result, so leave room for one to finish after the queue runs dry
  task automatic wait_drained();
    do @(negedge clk_i);
    while (beats_to_send.size() != 0 || in_valid_i || plot_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] tween, input logic anim,
                           input int tx, input int rx, input int count, input int plot_pct);
    write_cfg(CFG_TWEEN, tween);
    write_cfg(CFG_ANIM, CFG_DATA_BITS'(anim));
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    @(negedge clk_i);
    for (int i = 0; i < count; i++) push_random(plot_pct);
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: easing by sixteenths
    push_beat(KIND_PLOT, 0, 0, 0, T_ONE);
    push_beat(KIND_SET, 0, CMAX[CB-1:0], CMAX[CB-1:0], 0);
    push_beat(KIND_SET, 1, CMIN[CB-1:0], CMIN[CB-1:0], 0);
    push_beat(KIND_SET, 2, CMAX[CB-1:0], CMIN[CB-1:0], 0);
    push_beat(KIND_SET, 3, CMIN[CB-1:0], CMAX[CB-1:0], 0);
    push_beat(KIND_PLOT, 0, 0, 0, 32768);
    push_beat(KIND_TICK, 0, 0, 0, 0);
    push_beat(KIND_TICK, 3, -1, -1, '1);
    push_beat(KIND_PLOT, 0, 0, 0, 0);
    push_beat(KIND_PLOT, 0, 0, 0, T_ONE);
    push_beat(KIND_PLOT, 0, 0, 0, '1);
    push_beat(KIND_PLOT, 0, 0, 0, 1);
    push_beat(KIND_UNUSED, 2, rand_coord(), rand_coord(), rand_t());
    push_beat(KIND_PLOT, 0, 0, 0, 49152);
    wait_drained();

    // animation off with a zero divisor: sets land directly, ticks do nothing
    write_cfg(CFG_ANIM, '0);
    write_cfg(CFG_TWEEN, '0);
    @(negedge clk_i);
    push_beat(KIND_SET, 0, CMAX[CB-1:0], CMIN[CB-1:0], 0);
    push_beat(KIND_SET, 1, CMAX[CB-1:0], CMAX[CB-1:0], 0);
    push_beat(KIND_SET, 2, CMIN[CB-1:0], CMIN[CB-1:0], 0);
    push_beat(KIND_SET, 3, CMAX[CB-1:0], CMAX[CB-1:0], 0);
    push_beat(KIND_TICK, 0, 0, 0, 0);
    push_beat(KIND_PLOT, 0, 0, 0, 40000);
    push_beat(KIND_PLOT, 0, 0, 0, 65535);
    wait_drained();

    // zero divisor with animation on: a tick jumps to the target
    write_cfg(CFG_ANIM, 1);
    @(negedge clk_i);
    push_beat(KIND_SET, 3, 0, 0, 0);
    push_beat(KIND_TICK, 0, 0, 0, 0);
    push_beat(KIND_PLOT, 0, 0, 0, T_ONE);
    push_beat(KIND_PLOT, 0, 0, 0, 20000);
    wait_drained();

    run_phase(16, 1'b1, 0, 0, 300, 33);
    run_phase(1, 1'b1, 65, 0, 300, 33);
    run_phase(255, 1'b0, 0, 65, 300, 33);
    run_phase(CFG_DATA_BITS'($urandom_range(254, 2)), 1'b1, 21, 21, 300, 33);

    // long output hold-off while the sender keeps offering plots
    hold_arm = 1'b1;
    run_phase(3, 1'b1, 0, 0, 250, 75);

    run_phase(0, 1'b1, 21, 21, 300, 33);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
